FILE: rtl/core/pss_pkg.sv
// Shared types and constants for the priority scheduler.
package pss_pkg;

  localparam int NUM_READY = 3;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_FORK    = 3'd1,
    CMD_KILL    = 3'd2,
    CMD_EXIT    = 3'd3,
    CMD_QUANTUM = 3'd4,
    CMD_SEM_NEW = 3'd5,
    CMD_SEM_P   = 3'd6,
    CMD_SEM_V   = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_REFUSED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_END      = 3'd3,
    ST_FULL     = 3'd4,
    ST_BAD_SEM  = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CREATE,
    OP_PUSH,
    OP_KILL_CUR,
    OP_DISP_START,
    OP_DISP_TAKE,
    OP_SHIFT_RD,
    OP_SHIFT_WR,
    OP_SHIFT_END,
    OP_SCAN_INIT,
    OP_SCAN_HIT,
    OP_SCAN_NEXT,
    OP_QSAVE,
    OP_SEL_OLD,
    OP_SEL_CUR,
    OP_SEL_ENTQ,
    OP_ENT_LATCH,
    OP_SEM_NEW,
    OP_P_DEC,
    OP_V_INC,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    set_status;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic cur_idle;
    logic live_zero;
    logic table_full;
    logic any_ready;
    logic sem_bad;
    logic sem_made;
    logic sem_neg;
    logic tgt_zero;
    logic tgt_cur;
    logic scan_hit;
    logic scan_last;
    logic shift_more;
    logic q_full;
    logic q_nonempty;
    logic old_busy;
  } dp_flags_t;

endpackage

FILE: rtl/core/priority_scheduler_with_semaphores.sv
// Top level of the three-level priority scheduler with counting semaphores.
//
// One command word enters on the input channel (in_valid_i/in_ready_o) and
// exactly one result word leaves on the output channel (out_valid_o/
// out_ready_i). Commands are handled one at a time; in_ready_o is high only
// while the controller waits for a command.
// An exit that dispatches from a ready queue shifts each remaining entry of
// that queue down. A kill of a queued process walks the ready queues, probing
// up to 3*MAX_PROCS slots, then compacts the hit queue. All queues live in
// one memory with one write and one registered read port.
// The result sits in an output register: a stalled receiver does not block
// the next command, which is worked on until its own result needs that
// register.
// Reset leaves the idle process running, all queues empty, no semaphore
// created and the next PID at one. Queue memory needs no clearing.
module priority_scheduler_with_semaphores import pss_pkg::*; #(
  parameter int MAX_PROCS = 16,
  parameter int NUM_SEMS  = 5,
  parameter int PID_BITS  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        command_i,
  input  logic [1:0]        priority_req_i,
  input  logic [7:0]        target_pid_i,
  input  logic [2:0]        sem_id_i,
  input  logic signed [7:0] sem_initial_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [7:0]        result_pid_o,
  output logic [7:0]        running_pid_o,
  output logic [1:0]        running_priority_o
);

  dp_cmd_t   dp_cmd;
  dp_flags_t dp_flags;

  pss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .flags_i     (dp_flags),
    .cmd_o       (dp_cmd)
  );

  pss_dp #(
    .MAX_PROCS (MAX_PROCS),
    .NUM_SEMS  (NUM_SEMS),
    .PID_BITS  (PID_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (dp_cmd),
    .command_i          (command_i),
    .priority_req_i     (priority_req_i),
    .target_pid_i       (target_pid_i),
    .sem_id_i           (sem_id_i),
    .sem_initial_i      (sem_initial_i),
    .flags_o            (dp_flags),
    .status_o           (status_o),
    .result_pid_o       (result_pid_o),
    .running_pid_o      (running_pid_o),
    .running_priority_o (running_priority_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a second word without a gap");

  a_pri_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> running_priority_o != 2'd3)
    else $error("running priority out of range");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_END |-> running_pid_o == 8'd0 && result_pid_o == 8'd0)
    else $error("system end reported while a process runs");

  a_fail_no_pid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_BAD_SEM) |-> result_pid_o == 8'd0)
    else $error("failed command returned a pid");

endmodule

FILE: rtl/core/pss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pss_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/pss_dp.sv
// Scheduler datapath: process state, queue memory, counts and semaphores.
module pss_dp import pss_pkg::*; #(
  parameter int MAX_PROCS = 16,
  parameter int NUM_SEMS  = 5,
  parameter int PID_BITS  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  input  logic [2:0]         command_i,
  input  logic [1:0]         priority_req_i,
  input  logic [7:0]         target_pid_i,
  input  logic [2:0]         sem_id_i,
  input  logic signed [7:0]  sem_initial_i,
  output dp_flags_t          flags_o,
  output logic [2:0]         status_o,
  output logic [7:0]         result_pid_o,
  output logic [7:0]         running_pid_o,
  output logic [1:0]         running_priority_o
);

  localparam int NQ  = NUM_READY + NUM_SEMS;
  localparam int QW  = $clog2(NQ);
  localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW  = $clog2(MAX_PROCS + 1);
  localparam int SW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int EW  = PID_BITS + 2;
  localparam int TCW = (PID_BITS > 8) ? PID_BITS : 8;
  localparam int AW  = QW + IW;
  localparam int RAM_DEPTH = NQ * (2 ** IW);

  cmd_e                cmd_q, cmd_d;
  logic [1:0]          pri_q, pri_d;
  logic [7:0]          target_q, target_d;
  logic [2:0]          sid_q, sid_d;
  logic signed [7:0]   init_q, init_d;
  status_e             status_q, status_d;
  logic [PID_BITS-1:0] rpid_q, rpid_d;
  logic [PID_BITS-1:0] cur_pid_q, cur_pid_d;
  logic [1:0]          cur_pri_q, cur_pri_d;
  logic [PID_BITS-1:0] old_pid_q, old_pid_d;
  logic [1:0]          old_pri_q, old_pri_d;
  logic [PID_BITS-1:0] next_q, next_d;
  logic [CW-1:0]       live_q, live_d;
  logic [QW-1:0]       qsel_q, qsel_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [EW-1:0]       ent_q, ent_d;
  logic [CW-1:0]       cnt_q [NQ];
  logic [CW-1:0]       cnt_d [NQ];
  logic signed [7:0]   sem_q [NUM_SEMS];
  logic signed [7:0]   sem_d [NUM_SEMS];
  logic                made_q [NUM_SEMS];
  logic                made_d [NUM_SEMS];
  logic [2:0]          ostat_q, ostat_d;
  logic [7:0]          orpid_q, orpid_d;
  logic [7:0]          orun_q, orun_d;
  logic [1:0]          opri_q, opri_d;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [EW-1:0]       wdata, rdata;
  logic [PID_BITS-1:0] rd_pid;
  logic [1:0]          rd_pri;
  logic [7:0]          sid8;
  logic [SW-1:0]       sidx;
  logic [QW-1:0]       wq;
  logic [QW-1:0]       first;
  logic                any_ready;
  logic                sem_bad;
  logic [1:0]          new_pri;
  logic [CW-1:0]       cnt_sel;

  assign rd_pid    = rdata[PID_BITS-1:0];
  assign rd_pri    = rdata[EW-1:PID_BITS];
  assign sid8      = {5'b0, sid_q};
  assign sidx      = sid8[SW-1:0];
  assign wq        = QW'(NUM_READY) + QW'(sidx);
  assign sem_bad   = 32'(sid_q) >= 32'(NUM_SEMS);
  assign any_ready = (cnt_q[0] != '0) || (cnt_q[1] != '0) || (cnt_q[2] != '0);
  assign cnt_sel   = cnt_q[qsel_q];
  assign new_pri   = (cmd_q == CMD_FORK) ? cur_pri_q : pri_q;

  always_comb begin
    first = QW'(2);
    if (cnt_q[1] != '0) begin
      first = QW'(1);
    end
    if (cnt_q[0] != '0) begin
      first = QW'(0);
    end
  end

  always_comb begin
    cmd_d     = cmd_q;
    pri_d     = pri_q;
    target_d  = target_q;
    sid_d     = sid_q;
    init_d    = init_q;
    status_d  = status_q;
    rpid_d    = rpid_q;
    cur_pid_d = cur_pid_q;
    cur_pri_d = cur_pri_q;
    old_pid_d = old_pid_q;
    old_pri_d = old_pri_q;
    next_d    = next_q;
    live_d    = live_q;
    qsel_d    = qsel_q;
    idx_d     = idx_q;
    ent_d     = ent_q;
    cnt_d     = cnt_q;
    sem_d     = sem_q;
    made_d    = made_q;
    ostat_d   = ostat_q;
    orpid_d   = orpid_q;
    orun_d    = orun_q;
    opri_d    = opri_q;
    we        = 1'b0;
    waddr     = {qsel_q, idx_q};
    wdata     = ent_q;
    raddr     = {qsel_q, idx_q};
    if (cmd_i.set_status) begin
      status_d = cmd_i.status;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        cmd_d    = cmd_e'(command_i);
        pri_d    = (priority_req_i == 2'd3) ? 2'd2 : priority_req_i;
        target_d = target_pid_i;
        sid_d    = sem_id_i;
        init_d   = sem_initial_i;
        status_d = ST_DONE;
        rpid_d   = '0;
      end
      OP_CREATE: begin
        next_d = (next_q == '1) ? PID_BITS'(1) : next_q + PID_BITS'(1);
        live_d = live_q + CW'(1);
        rpid_d = next_q;
        if (cur_pid_q == '0) begin
          cur_pid_d = next_q;
          cur_pri_d = new_pri;
        end else begin
          qsel_d = QW'(new_pri);
          ent_d  = {new_pri, next_q};
        end
      end
      OP_PUSH: begin
        if (cnt_sel < CW'(MAX_PROCS)) begin
          we             = 1'b1;
          waddr          = {qsel_q, cnt_sel[IW-1:0]};
          cnt_d[qsel_q]  = cnt_sel + CW'(1);
        end
      end
      OP_KILL_CUR: begin
        rpid_d = cur_pid_q;
        if (live_q != '0) begin
          live_d = live_q - CW'(1);
        end
      end
      OP_DISP_START: begin
        if (any_ready) begin
          qsel_d = first;
          idx_d  = '0;
          raddr  = {first, IW'(0)};
        end else begin
          cur_pid_d = '0;
          cur_pri_d = 2'd0;
        end
      end
      OP_DISP_TAKE: begin
        cur_pid_d = rd_pid;
        cur_pri_d = rd_pri;
      end
      OP_SHIFT_RD: begin
        raddr = {qsel_q, idx_q + IW'(1)};
      end
      OP_SHIFT_WR: begin
        we    = 1'b1;
        waddr = {qsel_q, idx_q};
        wdata = rdata;
        idx_d = idx_q + IW'(1);
      end
      OP_SHIFT_END: begin
        if (cnt_sel != '0) begin
          cnt_d[qsel_q] = cnt_sel - CW'(1);
        end
      end
      OP_SCAN_INIT: begin
        qsel_d = '0;
        idx_d  = '0;
      end
      OP_SCAN_HIT: begin
        rpid_d = rd_pid;
        if (live_q != '0) begin
          live_d = live_q - CW'(1);
        end
      end
      OP_SCAN_NEXT: begin
        if (qsel_q == QW'(NUM_READY - 1)) begin
          qsel_d = '0;
          idx_d  = idx_q + IW'(1);
        end else begin
          qsel_d = qsel_q + QW'(1);
        end
      end
      OP_QSAVE: begin
        old_pid_d = cur_pid_q;
        old_pri_d = cur_pri_q;
      end
      OP_SEL_OLD: begin
        qsel_d = QW'(old_pri_q);
        ent_d  = {old_pri_q, old_pid_q};
      end
      OP_SEL_CUR: begin
        ent_d = {cur_pri_q, cur_pid_q};
      end
      OP_SEL_ENTQ: begin
        qsel_d = QW'(ent_q[EW-1:PID_BITS]);
      end
      OP_ENT_LATCH: begin
        ent_d = rdata;
      end
      OP_SEM_NEW: begin
        made_d[sidx] = 1'b1;
        sem_d[sidx]  = init_q;
        cnt_d[wq]    = '0;
      end
      OP_P_DEC: begin
        if (sem_q[sidx] != -8'sd128) begin
          sem_d[sidx] = sem_q[sidx] - 8'sd1;
        end
        qsel_d = wq;
        idx_d  = '0;
      end
      OP_V_INC: begin
        if (sem_q[sidx] != 8'sd127) begin
          sem_d[sidx] = sem_q[sidx] + 8'sd1;
        end
        qsel_d = wq;
        idx_d  = '0;
      end
      OP_FINISH: begin
        ostat_d = status_q;
        orpid_d = (cmd_q == CMD_QUANTUM) ? 8'(cur_pid_q) : 8'(rpid_q);
        orun_d  = 8'(cur_pid_q);
        opri_d  = cur_pri_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_pid_q <= '0;
      cur_pri_q <= 2'd0;
      next_q    <= PID_BITS'(1);
      live_q    <= '0;
      for (int i = 0; i < NQ; i++) begin
        cnt_q[i] <= '0;
      end
      for (int i = 0; i < NUM_SEMS; i++) begin
        sem_q[i]  <= '0;
        made_q[i] <= 1'b0;
      end
    end else begin
      cur_pid_q <= cur_pid_d;
      cur_pri_q <= cur_pri_d;
      next_q    <= next_d;
      live_q    <= live_d;
      cnt_q     <= cnt_d;
      sem_q     <= sem_d;
      made_q    <= made_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    pri_q     <= pri_d;
    target_q  <= target_d;
    sid_q     <= sid_d;
    init_q    <= init_d;
    status_q  <= status_d;
    rpid_q    <= rpid_d;
    old_pid_q <= old_pid_d;
    old_pri_q <= old_pri_d;
    qsel_q    <= qsel_d;
    idx_q     <= idx_d;
    ent_q     <= ent_d;
    ostat_q   <= ostat_d;
    orpid_q   <= orpid_d;
    orun_q    <= orun_d;
    opri_q    <= opri_d;
  end

  pss_ram #(
    .WIDTH (EW),
    .DEPTH (RAM_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    flags_o.cmd        = cmd_q;
    flags_o.cur_idle   = (cur_pid_q == '0);
    flags_o.live_zero  = (live_q == '0);
    flags_o.table_full = (live_q >= CW'(MAX_PROCS));
    flags_o.any_ready  = any_ready;
    flags_o.sem_bad    = sem_bad;
    flags_o.sem_made   = !sem_bad && made_q[sidx];
    flags_o.sem_neg    = sem_q[sidx][7];
    flags_o.tgt_zero   = (target_q == 8'd0);
    flags_o.tgt_cur    = (TCW'(target_q) == TCW'(cur_pid_q));
    flags_o.scan_hit   = (CW'(idx_q) < cnt_sel) && (TCW'(rd_pid) == TCW'(target_q));
    flags_o.scan_last  = (qsel_q == QW'(NUM_READY - 1)) && (idx_q == IW'(MAX_PROCS - 1));
    flags_o.shift_more = ((CW + 1)'(idx_q) + (CW + 1)'(1)) < (CW + 1)'(cnt_sel);
    flags_o.q_full     = (cnt_sel >= CW'(MAX_PROCS));
    flags_o.q_nonempty = (cnt_sel != '0);
    flags_o.old_busy   = (old_pid_q != '0);
  end

  assign status_o           = ostat_q;
  assign result_pid_o       = orpid_q;
  assign running_pid_o      = orun_q;
  assign running_priority_o = opri_q;

endmodule

FILE: rtl/core/pss_ctrl.sv
// Scheduler controller: command sequencing and handshake state machine.
module pss_ctrl import pss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_flags_t flags_i,
  output dp_cmd_t   cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_MK, S_PUSH, S_KCUR, S_DSTART, S_DTAKE,
    S_SH_CHK, S_SH_RD, S_SH_WR, S_SH_END,
    S_SCAN_INIT, S_SCAN_RD, S_SCAN_CHK,
    S_QSAVE, S_SEL_OLD, S_PDEC, S_PCHK, S_PSEL,
    S_VINC, S_VCHK, S_VLATCH, S_SEL_ENTQ, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d          = state_q;
    out_valid_d      = out_valid_q;
    cmd_o.op         = OP_NONE;
    cmd_o.set_status = 1'b0;
    cmd_o.status     = ST_DONE;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FIN;
        case (flags_i.cmd)
          CMD_CREATE, CMD_FORK: begin
            if (flags_i.cmd == CMD_FORK && flags_i.cur_idle) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_REFUSED;
            end else if (flags_i.table_full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              state_d = S_MK;
            end
          end
          CMD_KILL, CMD_EXIT: begin
            if ((flags_i.cmd == CMD_KILL && flags_i.tgt_zero) ||
                (flags_i.cmd == CMD_EXIT && flags_i.cur_idle)) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = flags_i.live_zero ? ST_END : ST_REFUSED;
            end else if (flags_i.cmd == CMD_EXIT || flags_i.tgt_cur) begin
              state_d = S_KCUR;
            end else begin
              state_d = S_SCAN_INIT;
            end
          end
          CMD_QUANTUM: begin
            if (flags_i.any_ready) begin
              state_d = S_QSAVE;
            end
          end
          default: begin
            if (flags_i.sem_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BAD_SEM;
            end else if (flags_i.cmd == CMD_SEM_NEW) begin
              if (flags_i.sem_made) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = ST_REFUSED;
              end else begin
                cmd_o.op = OP_SEM_NEW;
              end
            end else if (!flags_i.sem_made) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_REFUSED;
            end else if (flags_i.cmd == CMD_SEM_P) begin
              state_d = S_PDEC;
            end else begin
              state_d = S_VINC;
            end
          end
        endcase
      end
      S_MK: begin
        cmd_o.op = OP_CREATE;
        state_d  = flags_i.cur_idle ? S_FIN : S_PUSH;
      end
      S_PUSH: begin
        cmd_o.op = OP_PUSH;
        state_d  = (flags_i.cmd == CMD_SEM_P) ? S_DSTART : S_FIN;
      end
      S_KCUR: begin
        cmd_o.op = OP_KILL_CUR;
        state_d  = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.op = OP_DISP_START;
        state_d  = flags_i.any_ready ? S_DTAKE : S_FIN;
      end
      S_DTAKE: begin
        cmd_o.op = OP_DISP_TAKE;
        state_d  = S_SH_CHK;
      end
      S_SH_CHK: begin
        state_d = flags_i.shift_more ? S_SH_RD : S_SH_END;
      end
      S_SH_RD: begin
        cmd_o.op = OP_SHIFT_RD;
        state_d  = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.op = OP_SHIFT_WR;
        state_d  = S_SH_CHK;
      end
      S_SH_END: begin
        cmd_o.op = OP_SHIFT_END;
        if (flags_i.cmd == CMD_QUANTUM && flags_i.old_busy) begin
          state_d = S_SEL_OLD;
        end else if (flags_i.cmd == CMD_SEM_V) begin
          state_d = S_SEL_ENTQ;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCAN_INIT: begin
        cmd_o.op = OP_SCAN_INIT;
        state_d  = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (flags_i.scan_hit) begin
          cmd_o.op = OP_SCAN_HIT;
          state_d  = S_SH_CHK;
        end else if (flags_i.scan_last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOT_FOUND;
          state_d          = S_FIN;
        end else begin
          cmd_o.op = OP_SCAN_NEXT;
          state_d  = S_SCAN_RD;
        end
      end
      S_QSAVE: begin
        cmd_o.op = OP_QSAVE;
        state_d  = S_DSTART;
      end
      S_SEL_OLD: begin
        cmd_o.op = OP_SEL_OLD;
        state_d  = S_PUSH;
      end
      S_PDEC: begin
        cmd_o.op = OP_P_DEC;
        state_d  = S_PCHK;
      end
      S_PCHK: begin
        if (!flags_i.sem_neg) begin
          state_d = S_FIN;
        end else if (flags_i.cur_idle || flags_i.q_full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_REFUSED;
          state_d          = S_FIN;
        end else begin
          state_d = S_PSEL;
        end
      end
      S_PSEL: begin
        cmd_o.op = OP_SEL_CUR;
        state_d  = S_PUSH;
      end
      S_VINC: begin
        cmd_o.op = OP_V_INC;
        state_d  = S_VCHK;
      end
      S_VCHK: begin
        state_d = flags_i.q_nonempty ? S_VLATCH : S_FIN;
      end
      S_VLATCH: begin
        cmd_o.op = OP_ENT_LATCH;
        state_d  = S_SH_CHK;
      end
      S_SEL_ENTQ: begin
        cmd_o.op = OP_SEL_ENTQ;
        state_d  = S_PUSH;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
